// ----- sv/hash_map_table_engine_unit_assert.svh -----
// Assertion macros shared by the checker of hash_map_table_engine_unit.
// Depends on nothing. Each macro expects clk_i and rst_ni in scope.
`ifndef HASH_MAP_TABLE_ENGINE_UNIT_ASSERT_SVH
`define HASH_MAP_TABLE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define HMTE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HMTE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/hmte_pkg.sv -----
// Package of the hash map table engine: widths, operation and status codes,
// and the word types that travel along the cell row. Depends on nothing.
package hmte_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned TOTAL_W  = 9;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_PUT    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NULL_KEY = 2'd2
  } status_e;

  // One stored entry.
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } ent_t;

  // Operation word walking the row.
  typedef struct packed {
    logic             vld;
    logic             shift;   // remove hit: compacting the row behind it
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic             found;
    logic [VAL_W-1:0] old;
  } tok_t;

  // Completion report of one cell.
  typedef struct packed {
    logic             vld;
    logic             found;
    logic [VAL_W-1:0] old;
    logic             ins;
    logic             rem;
    logic             full;
  } fin_t;

endpackage

// ----- sv/hmte_cell.sv -----
// One storage cell of the hash map row: holds one entry and one operation word.
// Depends on hmte_pkg.
module hmte_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hmte_pkg::tok_t tok_i,   // word from left neighbor
  input  hmte_pkg::ent_t nb_i,    // entry of right neighbor, for compaction
  output hmte_pkg::tok_t tok_o,   // word to right neighbor
  output hmte_pkg::ent_t ent_o,
  output hmte_pkg::fin_t fin_o
);

  hmte_pkg::ent_t ent_q, ent_d;
  hmte_pkg::tok_t tok_q;

  always_comb begin
    ent_d     = ent_q;
    tok_o     = tok_q;
    tok_o.vld = 1'b0;
    fin_o     = '0;
    if (tok_q.vld) begin
      if (tok_q.shift) begin
        // pull neighbor left; stop at the first empty cell
        ent_d = nb_i;
        if (ent_q.vld) begin
          tok_o.vld = 1'b1;
        end else begin
          fin_o.vld   = 1'b1;
          fin_o.found = tok_q.found;
          fin_o.old   = tok_q.old;
          fin_o.rem   = 1'b1;
        end
      end else if (!ent_q.vld) begin
        // end of occupied region: key absent
        fin_o.vld = 1'b1;
        if (hmte_pkg::op_e'(tok_q.op) == hmte_pkg::OP_PUT) begin
          ent_d.vld = 1'b1;
          ent_d.key = tok_q.key;
          ent_d.val = tok_q.val;
          fin_o.ins = 1'b1;
        end
      end else if (ent_q.key == tok_q.key) begin
        case (hmte_pkg::op_e'(tok_q.op))
          hmte_pkg::OP_PUT: begin
            ent_d.val   = tok_q.val;
            fin_o.vld   = 1'b1;
            fin_o.found = 1'b1;
            fin_o.old   = ent_q.val;
          end
          hmte_pkg::OP_REMOVE: begin
            ent_d       = nb_i;
            tok_o.vld   = 1'b1;
            tok_o.shift = 1'b1;
            tok_o.found = 1'b1;
            tok_o.old   = ent_q.val;
          end
          default: begin
            fin_o.vld   = 1'b1;
            fin_o.found = 1'b1;
            fin_o.old   = ent_q.val;
          end
        endcase
      end else begin
        tok_o.vld = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      tok_q <= '0;
    end else begin
      ent_q <= ent_d;
      tok_q <= tok_i;
    end
  end

  assign ent_o = ent_q;

endmodule

// ----- sv/hash_map_table_engine_unit.sv -----
// Top level of the hash map table engine: cell row, completion collect, result register.
// Depends on hmte_pkg and hmte_cell.
//
// Key to value map over a row of CAPACITY cells, each holding one entry.
// Occupied cells are kept packed at the front of the row. An operation word
// enters cell 0 and moves one cell per clock, comparing its key on the way:
// a hit completes get and put on the spot, a put that reaches the first empty
// cell stores its key there, and a remove empties the hit cell and then walks
// on, pulling each later entry one cell left until the row is packed again.
// A word issued with start while busy is low is taken; busy then stays high
// and falls in the cycle that shows done_o, and a zero key never raises it.
// Cost per item is set by the walk along the row: a get or put ends at the
// hit cell, or for an absent key at the first empty cell; an absent key in a
// full row falls off the end of the row, the longest walk of any item. A
// remove of an entry walks on to the first empty cell, or off the end in a
// full row; a zero key is answered in the cycle after acceptance. A new item
// may be started in the cycle that shows done_o. Each result stands on
// found_o, old_value_o, status_o and entry_total_o for the single cycle that
// done_o is high; the receiver cannot stall it, so it must capture it then.
// status_o is 0 ok, 1 put refused because every cell is in use, 2 zero key
// rejected (nothing changes). Op code 3 behaves as a get. Results never
// depend on placement.
module hash_map_table_engine_unit #(
  parameter int unsigned CAPACITY = hmte_pkg::CAPACITY
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [1:0]                    op_i,
  input  logic [hmte_pkg::KEY_W-1:0]    key_i,
  input  logic [hmte_pkg::VAL_W-1:0]    new_value_i,
  output logic                          busy,
  output logic                          done_o,
  output logic                          found_o,
  output logic [hmte_pkg::VAL_W-1:0]    old_value_o,
  output logic [1:0]                    status_o,
  output logic [hmte_pkg::TOTAL_W-1:0]  entry_total_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Words between cells: tok_w[0] is injected, tok_w[CAPACITY] falls off the end.
  hmte_pkg::tok_t tok_w [CAPACITY+1];
  hmte_pkg::ent_t ent_w [CAPACITY+1];
  hmte_pkg::fin_t fin_w [CAPACITY];
  hmte_pkg::fin_t fin_any;

  logic             busy_q;
  logic             accept;
  logic             null_key;
  logic [CNT_W-1:0] count_q, count_d;

  logic                         done_q;
  logic                         found_q;
  logic [hmte_pkg::VAL_W-1:0]   old_q;
  logic [1:0]                   status_q;
  logic [hmte_pkg::TOTAL_W-1:0] total_q;

  assign accept   = start && !busy_q;
  assign null_key = (key_i == '0);

  always_comb begin
    tok_w[0]       = '0;
    tok_w[0].vld   = accept && !null_key;
    tok_w[0].op    = op_i;
    tok_w[0].key   = key_i;
    tok_w[0].val   = new_value_i;
  end

  // The slot past the last cell reads as empty.
  assign ent_w[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    hmte_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_w[i]),
      .nb_i   (ent_w[i+1]),
      .tok_o  (tok_w[i+1]),
      .ent_o  (ent_w[i]),
      .fin_o  (fin_w[i])
    );
  end

  // At most one cell completes per cycle, so an OR merge suffices.
  always_comb begin
    fin_any = '0;
    // Word off the end: a search found nothing in a full row, or a
    // compaction ran through the last cell.
    if (tok_w[CAPACITY].vld) begin
      fin_any.vld   = 1'b1;
      fin_any.found = tok_w[CAPACITY].found;
      fin_any.old   = tok_w[CAPACITY].old;
      fin_any.rem   = tok_w[CAPACITY].shift;
      fin_any.full  = !tok_w[CAPACITY].shift &&
                      (hmte_pkg::op_e'(tok_w[CAPACITY].op) == hmte_pkg::OP_PUT);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      fin_any = fin_any | fin_w[i];
    end
  end

  assign count_d = count_q + CNT_W'(fin_any.ins) - CNT_W'(fin_any.rem);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (accept && !null_key) begin
        busy_q <= 1'b1;
      end else if (fin_any.vld) begin
        busy_q <= 1'b0;
      end
      if (fin_any.vld) begin
        count_q <= count_d;
      end
      done_q <= fin_any.vld || (accept && null_key);
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (fin_any.vld) begin
      found_q  <= fin_any.found;
      old_q    <= fin_any.old;
      status_q <= fin_any.full ? hmte_pkg::ST_FULL : hmte_pkg::ST_OK;
      total_q  <= hmte_pkg::TOTAL_W'(count_d);
    end else if (accept && null_key) begin
      found_q  <= 1'b0;
      old_q    <= '0;
      status_q <= hmte_pkg::ST_NULL_KEY;
      total_q  <= hmte_pkg::TOTAL_W'(count_q);
    end
  end

  assign busy          = busy_q;
  assign done_o        = done_q;
  assign found_o       = found_q;
  assign old_value_o   = old_q;
  assign status_o      = status_q;
  assign entry_total_o = total_q;

endmodule

// ----- sv/hmte_chk.sv -----
// Port-level checker for hash_map_table_engine_unit, bound to the top level.
// Depends on hmte_pkg and hash_map_table_engine_unit_assert.svh.
`include "hash_map_table_engine_unit_assert.svh"

module hmte_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic [hmte_pkg::KEY_W-1:0]   key_i,
  input logic                         busy,
  input logic                         done_o,
  input logic                         found_o,
  input logic [hmte_pkg::VAL_W-1:0]   old_value_o,
  input logic [1:0]                   status_o
);

  `HMTE_ASSERT_IMP(a_miss_zero, done_o && !found_o, old_value_o == '0,
                   "miss with nonzero value")
  `HMTE_ASSERT_IMP(a_full_miss, done_o && status_o == hmte_pkg::ST_FULL, !found_o,
                   "full put hit")
  `HMTE_ASSERT_NXT(a_null_key, start && !busy && key_i == '0,
                   done_o && status_o == hmte_pkg::ST_NULL_KEY, "null key not rejected")
  `HMTE_ASSERT_IMP(a_busy_end, $fell(busy), done_o, "busy ended without result")

endmodule

bind hash_map_table_engine_unit hmte_chk u_hmte_chk (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for hash_map_table_engine_unit: the key/value map, full-pool
// refusal, zero-key rejection and the op code that decodes as get.
// Depends on hmte_pkg and the RTL of hash_map_table_engine_unit only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Op code 3 is not assigned; the block decodes it as a get.
  localparam logic [1:0] OP_ALIAS_GET = 2'd3;
  localparam int unsigned POOL_KEYS = 64;
  // Longest walk is a full row plus the result register, plus some slack.
  localparam int unsigned DRAIN_CYCLES = hmte_pkg::CAPACITY + 8;

  // Expected outcome of one word, plus what caused it for messages.
  typedef struct {
    logic [1:0]                   op;
    logic [hmte_pkg::KEY_W-1:0]   key;
    logic                         found;
    logic [hmte_pkg::VAL_W-1:0]   old;
    hmte_pkg::status_e            status;
    logic [hmte_pkg::TOTAL_W-1:0] total;
  } map_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         start;
  logic [1:0]                   op_i;
  logic [hmte_pkg::KEY_W-1:0]   key_i;
  logic [hmte_pkg::VAL_W-1:0]   new_value_i;
  logic                         busy;
  logic                         done_o;
  logic                         found_o;
  logic [hmte_pkg::VAL_W-1:0]   old_value_o;
  logic [1:0]                   status_o;
  logic [hmte_pkg::TOTAL_W-1:0] entry_total_o;

  // Shadow copy of the stored map: key -> value. Placement in the block is
  // irrelevant to the results, so a plain associative array is enough.
  logic [hmte_pkg::VAL_W-1:0]   shadow_map [logic [hmte_pkg::KEY_W-1:0]];
  map_result_t                  pending_results [$];
  logic [hmte_pkg::KEY_W-1:0]   key_pool [POOL_KEYS];

  bit                   sender_gaps;
  int unsigned          err_count;
  int unsigned          word_count;
  int unsigned          hit_count;
  int unsigned          full_count;
  int unsigned          null_count;
  int unsigned          peak_total;

  hash_map_table_engine_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .op_i          (op_i),
    .key_i         (key_i),
    .new_value_i   (new_value_i),
    .busy          (busy),
    .done_o        (done_o),
    .found_o       (found_o),
    .old_value_o   (old_value_o),
    .status_o      (status_o),
    .entry_total_o (entry_total_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one word to the shadow map and returns its outcome.
  // A zero key touches nothing. A put of an absent key needs a free entry,
  // otherwise it is refused with the map unchanged. A put of a present key
  // always replaces. Remove of an absent key is a plain miss.
  // ---------------------------------------------------------------------------
  function automatic map_result_t apply_to_shadow_map(logic [1:0] op,
                                                      logic [hmte_pkg::KEY_W-1:0] key,
                                                      logic [hmte_pkg::VAL_W-1:0] val);
    map_result_t r;
    r.op     = op;
    r.key    = key;
    r.found  = 1'b0;
    r.old    = '0;
    r.status = hmte_pkg::ST_OK;
    if (key == '0) begin
      r.status = hmte_pkg::ST_NULL_KEY;
    end else begin
      if (shadow_map.exists(key)) begin
        r.found = 1'b1;
        r.old   = shadow_map[key];
      end
      if (op == hmte_pkg::OP_PUT) begin
        if (!r.found && shadow_map.num() >= hmte_pkg::CAPACITY) begin
          r.status = hmte_pkg::ST_FULL;
        end else begin
          shadow_map[key] = val;
        end
      end else if (op == hmte_pkg::OP_REMOVE && r.found) begin
        shadow_map.delete(key);
      end
    end
    r.total = hmte_pkg::TOTAL_W'(shadow_map.num());
    return r;
  endfunction

  // Random nonzero key that is not stored right now.
  function automatic logic [hmte_pkg::KEY_W-1:0] fresh_key();
    logic [hmte_pkg::KEY_W-1:0] k;
    do k = $urandom; while (k == '0 || shadow_map.exists(k));
    return k;
  endfunction

  // Random key among those stored; a fresh one if the map is empty.
  function automatic logic [hmte_pkg::KEY_W-1:0] stored_key();
    logic [hmte_pkg::KEY_W-1:0] keys [$];
    foreach (shadow_map[k]) keys.push_back(k);
    if (keys.size() == 0) return fresh_key();
    return keys[$urandom_range(0, keys.size() - 1)];
  endfunction

  function automatic logic [hmte_pkg::VAL_W-1:0] any_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want,
                                 map_result_t r);
    $display("[%0t] mismatch on %s: got %h want %h (op %0d key %h)",
             $realtime, what, got, want, r.op, r.key);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Send one word. start stays high across back-to-back words; when a gap is
  // taken it is dropped first, sometimes only after the block went idle so
  // the gap lands on the idle phase rather than inside a walk.
  // The word is taken at the edge where start is high and busy was low.
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [1:0] op, logic [hmte_pkg::KEY_W-1:0] key,
                           logic [hmte_pkg::VAL_W-1:0] val);
    map_result_t r;
    if (sender_gaps && $urandom_range(0, 99) < 35) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk_i); while (busy);
      end
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start       <= 1'b1;
    op_i        <= op;
    key_i       <= key;
    new_value_i <= val;
    do @(posedge clk_i); while (busy);
    r = apply_to_shadow_map(op, key, val);
    pending_results.push_back(r);
    word_count++;
    if (r.found) hit_count++;
    if (r.status == hmte_pkg::ST_FULL) full_count++;
    if (r.status == hmte_pkg::ST_NULL_KEY) null_count++;
    if (r.total > peak_total) peak_total = 32'(r.total);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker. The result is only valid in the done_o cycle, so it is
  // sampled at the edge that closes it. A new word can be taken at that same
  // edge; its expectation goes to the back, so the front is still ours.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    map_result_t r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("[%0t] result word with nothing outstanding", $realtime);
        err_count++;
      end else begin
        r = pending_results.pop_front();
        if (found_o !== r.found)
          report_mismatch("found", 32'(found_o), 32'(r.found), r);
        if (old_value_o !== r.old) report_mismatch("old_value", old_value_o, r.old, r);
        if (status_o !== r.status)
          report_mismatch("status", 32'(status_o), 32'(r.status), r);
        if (entry_total_o !== r.total)
          report_mismatch("entry_total", 32'(entry_total_o), 32'(r.total), r);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short hand-picked sequence. Keys 1, 0x401 and 0x802 are stored in that order
  // behind 0xFFFFFFFF, so removes hit the middle and the tail of the occupied row.
  task automatic test_directed();
    send_word(hmte_pkg::OP_GET,    32'h0000_0001, 32'hFFFF_FFFF); // miss on empty map
    send_word(hmte_pkg::OP_REMOVE, 32'h0000_0001, 32'h0);         // remove of absent key
    send_word(hmte_pkg::OP_GET,    32'h0,         32'h0);         // zero key, every op
    send_word(hmte_pkg::OP_PUT,    32'h0,         32'hFFFF_FFFF);
    send_word(hmte_pkg::OP_REMOVE, 32'h0,         32'h0);
    send_word(OP_ALIAS_GET,        32'h0,         32'h0);
    send_word(hmte_pkg::OP_PUT,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(hmte_pkg::OP_PUT,    32'h0000_0001, 32'h0);
    send_word(hmte_pkg::OP_PUT,    32'h0000_0401, 32'h0000_0401);
    send_word(hmte_pkg::OP_PUT,    32'h0000_0802, 32'h1234_5678);
    send_word(hmte_pkg::OP_GET,    32'h0000_0001, 32'hFFFF_FFFF);
    send_word(OP_ALIAS_GET,        32'h0000_0401, 32'h0);
    send_word(hmte_pkg::OP_GET,    32'h0000_0802, 32'h0);
    send_word(hmte_pkg::OP_PUT,    32'h0000_0401, 32'hA5A5_A5A5); // replace
    send_word(hmte_pkg::OP_GET,    32'h0000_0401, 32'h0);
    send_word(hmte_pkg::OP_REMOVE, 32'h0000_0401, 32'h0);         // middle of row
    send_word(hmte_pkg::OP_GET,    32'h0000_0401, 32'h0);
    send_word(hmte_pkg::OP_REMOVE, 32'h0000_0802, 32'h0);         // tail of row
    send_word(hmte_pkg::OP_REMOVE, 32'h0000_0001, 32'h0);         // tail of row
    send_word(hmte_pkg::OP_GET,    32'hFFFF_FFFF, 32'h0);
    send_word(hmte_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_word(hmte_pkg::OP_GET,    32'hFFFF_FFFF, 32'h0);
    send_word(hmte_pkg::OP_PUT,    32'h8000_0000, 32'h8000_0000);
    send_word(OP_ALIAS_GET,        32'h8000_0000, 32'h0);
  endtask

  // Fill every entry, then poke the full map: refusals, replace and zero key
  // while full, and a remove that frees exactly one entry.
  task automatic test_fill_to_capacity();
    logic [hmte_pkg::KEY_W-1:0] k;
    while (shadow_map.num() < hmte_pkg::CAPACITY)
      send_word(hmte_pkg::OP_PUT, fresh_key(), any_value());
    send_word(hmte_pkg::OP_PUT, fresh_key(), any_value());
    send_word(hmte_pkg::OP_PUT, fresh_key(), 32'hFFFF_FFFF);
    send_word(hmte_pkg::OP_PUT, stored_key(), any_value());
    send_word(hmte_pkg::OP_GET, stored_key(), 32'h0);
    send_word(OP_ALIAS_GET, stored_key(), 32'h0);
    send_word(hmte_pkg::OP_PUT, 32'h0, any_value());
    k = stored_key();
    send_word(hmte_pkg::OP_REMOVE, k, 32'h0);
    send_word(hmte_pkg::OP_PUT, fresh_key(), any_value());
    send_word(hmte_pkg::OP_PUT, k, any_value());              // refused again
  endtask

  // Random traffic hovering at the full mark: new puts are refused or taken
  // depending on how many removes came before.
  task automatic test_churn_when_full();
    int unsigned r;
    repeat (300) begin
      r = $urandom_range(0, 99);
      if (r < 35)      send_word(hmte_pkg::OP_PUT, fresh_key(), any_value());
      else if (r < 50) send_word(hmte_pkg::OP_PUT, stored_key(), any_value());
      else if (r < 65) send_word(hmte_pkg::OP_GET, stored_key(), any_value());
      else if (r < 70) send_word(OP_ALIAS_GET, stored_key(), any_value());
      else if (r < 95) send_word(hmte_pkg::OP_REMOVE, stored_key(), any_value());
      else             send_word(2'($urandom_range(0, 3)), 32'h0, any_value());
    end
  endtask

  // Remove everything in random order, with a get now and then.
  task automatic test_drain();
    logic [hmte_pkg::KEY_W-1:0] k;
    while (shadow_map.num() > 0) begin
      k = stored_key();
      if ($urandom_range(0, 4) == 0) send_word(hmte_pkg::OP_GET, k, any_value());
      send_word(hmte_pkg::OP_REMOVE, k, any_value());
    end
    send_word(hmte_pkg::OP_REMOVE, fresh_key(), any_value());
    send_word(hmte_pkg::OP_GET, fresh_key(), any_value());
  endtask

  // Main random mix over a small key set, so hits, replaces and removes are
  // frequent; a few wild and zero keys on top.
  // The first stretch runs with no sender gaps at all.
  task automatic test_random_mix(int unsigned n);
    logic [21:0]                hi_part [4];
    logic [7:0]                 bucket_part [16];
    logic [hmte_pkg::KEY_W-1:0] k;
    logic [1:0]                 op;
    int unsigned                r;
    foreach (hi_part[i]) hi_part[i] = 22'($urandom);
    foreach (bucket_part[i]) bucket_part[i] = 8'($urandom);
    foreach (key_pool[i]) begin
      k = {hi_part[i % 4], bucket_part[(i / 4) % 16], 2'($urandom)};
      key_pool[i] = (k == '0) ? 32'h1 : k;
    end
    sender_gaps = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 250) sender_gaps = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 38)      op = hmte_pkg::OP_PUT;
      else if (r < 66) op = hmte_pkg::OP_GET;
      else if (r < 93) op = hmte_pkg::OP_REMOVE;
      else             op = OP_ALIAS_GET;
      r = $urandom_range(0, 99);
      if (r < 3)       k = '0;
      else if (r < 12) k = $urandom;
      else             k = key_pool[$urandom_range(0, POOL_KEYS - 1)];
      send_word(op, k, any_value());
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    op_i        <= hmte_pkg::OP_GET;
    key_i       <= '0;
    new_value_i <= '0;
    sender_gaps = 1'b1;
    err_count   = 0;
    word_count  = 0;
    hit_count   = 0;
    full_count  = 0;
    null_count  = 0;
    peak_total  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_to_capacity();
    test_churn_when_full();
    test_drain();
    test_random_mix(600);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // Any stray result word would show up within one full walk.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d words: %0d hits, %0d full-pool refusals, %0d zero keys",
             word_count, hit_count, full_count, null_count);
    $display("map grew to %0d entries at most and was drained to empty along the way",
             peak_total);
    if (err_count == 0) begin
      $display("** hash_map_table_engine_unit: PASSED **");
    end else begin
      $display("** hash_map_table_engine_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run (every word a full walk).
  initial begin
    #40ms;
    $display("[%0t] timeout, %0d results outstanding", $realtime, pending_results.size());
    $display("** hash_map_table_engine_unit: FAILED **");
    $finish;
  end

endmodule
